[hdl/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
`define ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, a, b, msg)
`define ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

[hdl/mkh_pkg.sv]
`timescale 1ns / 1ps
package mkh_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'd5381;

	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_SEED = 3'd0;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_MIX  = 2'd0;
	localparam kind_t KIND_TAIL = 2'd1;
	localparam kind_t KIND_NONE = 2'd2;

	typedef struct packed {
		kind_t       kind;
		logic        first;
		logic        last;
		logic [30:0] klen;
		logic [31:0] data;
	} entry_t;

	typedef struct packed {
		logic valid_s1;
		logic valid_s2;
	} front_stat_t;

endpackage

[hdl/mkh_front.sv]
`timescale 1ns / 1ps
module mkh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [31:0]          data_word,
	input  logic [2:0]           byte_count,
	input  logic [30:0]          key_length,
	input  logic                 first_chunk,
	input  logic                 last_chunk,
	output logic                 q_push,
	input  logic                 q_full,
	output mkh_pkg::entry_t      q_entry,
	output mkh_pkg::front_stat_t stat
);
	import mkh_pkg::*;

	logic        en;
	logic        valid_s1;
	logic        valid_s2;
	entry_t      ent_s1;
	entry_t      ent_s2;
	kind_t       kind_in;
	logic [31:0] tail_word;
	logic [31:0] k_mixed;

	assign en     = !(valid_s2 && q_full);
	assign full   = !en;
	assign q_push = valid_s2 && !q_full;

	always_comb begin
		case (byte_count)
			3'd1:    tail_word = {24'd0, data_word[7:0]};
			3'd2:    tail_word = {16'd0, data_word[15:0]};
			3'd3:    tail_word = {8'd0, data_word[23:0]};
			default: tail_word = 32'd0;
		endcase
		if (last_chunk && byte_count < 3'd4) begin
			kind_in = (byte_count == 3'd0) ? KIND_NONE : KIND_TAIL;
		end else begin
			kind_in = KIND_MIX;
		end
	end

	// second half of the k mix: k ^= k >> 24, k *= M
	assign k_mixed = (ent_s1.data ^ (ent_s1.data >> MIX_SHIFT)) * MIX_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= push;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s1.kind  <= kind_in;
			ent_s1.first <= first_chunk;
			ent_s1.last  <= last_chunk;
			ent_s1.klen  <= key_length;
			ent_s1.data  <= (kind_in == KIND_MIX) ? data_word * MIX_MUL : tail_word;
			ent_s2.kind  <= ent_s1.kind;
			ent_s2.first <= ent_s1.first;
			ent_s2.last  <= ent_s1.last;
			ent_s2.klen  <= ent_s1.klen;
			ent_s2.data  <= (ent_s1.kind == KIND_MIX) ? k_mixed : ent_s1.data;
		end
	end

	assign q_entry       = ent_s2;
	assign stat.valid_s1 = valid_s1;
	assign stat.valid_s2 = valid_s2;

endmodule

[hdl/mkh_fifo.sv]
`timescale 1ns / 1ps
module mkh_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  mkh_pkg::entry_t wr_entry,
	output logic            q_full,
	input  logic            rd_en,
	output mkh_pkg::entry_t rd_entry,
	output logic            q_empty
);
	import mkh_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full   = (count_q == FULL_CNT);
	assign q_empty  = (count_q == '0);
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && !q_empty;
	assign rd_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

[hdl/mkh_back.sv]
`timescale 1ns / 1ps
module mkh_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     seed,
	input  logic            q_empty,
	input  mkh_pkg::entry_t q_entry,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     hash_value
);
	import mkh_pkg::*;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_FIN1 = 2'd1;
	localparam logic [1:0] ST_FIN2 = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] h_q;
	logic [31:0] fin_q;
	logic [31:0] out_q;
	logic        out_v_q;
	logic [31:0] h_base;
	logic [31:0] h_next;
	logic        out_take;
	logic        out_load;

	assign q_pop    = (state_q == ST_RUN) && !q_empty;
	assign out_take = pop && out_v_q;
	assign out_load = (state_q == ST_FIN2) && (!out_v_q || out_take);

	always_comb begin
		h_base = q_entry.first ? (seed ^ {1'b0, q_entry.klen}) : h_q;
		case (q_entry.kind)
			KIND_MIX:  h_next = (h_base * MIX_MUL) ^ q_entry.data;
			KIND_TAIL: h_next = (h_base ^ q_entry.data) * MIX_MUL;
			default:   h_next = h_base;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			h_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (q_pop) begin
						h_q <= h_next;
						if (q_entry.last) begin
							state_q <= ST_FIN1;
						end
					end
				end
				ST_FIN1: begin
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					if (out_load) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// final mix split around the multiply
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN1) begin
			fin_q <= (h_q ^ (h_q >> FIN_SHIFT_A)) * MIX_MUL;
		end
		if (out_load) begin
			out_q <= fin_q ^ (fin_q >> FIN_SHIFT_B);
		end
	end

	assign empty      = !out_v_q;
	assign hash_value = out_q;

endmodule

[hdl/murmur2_key_hash_unit.sv]
`timescale 1ns / 1ps
// 32-bit MurmurHash2 over a key streamed as little-endian 32-bit chunks. The front takes one
// chunk per cycle while not stalled by a full queue and runs the two k-mixing multiplies in a
// two-stage pipeline, then drops the chunk into a QUEUE_DEPTH-entry queue. The back folds one
// queued chunk per cycle into the running hash (one multiply and xor) while in its run state;
// after a last chunk it passes through the FIN1 state for the final mix multiply and the FIN2
// state, which waits for the result register to be free before loading it. The seed register
// sits at address 0 and should only be written while no key is in flight.
module murmur2_key_hash_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mkh_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         push,
	output logic                         full,
	input  logic [31:0]                  data_word,
	input  logic [2:0]                   byte_count,
	input  logic [30:0]                  key_length,
	input  logic                         first_chunk,
	input  logic                         last_chunk,
	output logic                         empty,
	input  logic                         pop,
	output logic [31:0]                  hash_value
);
	import mkh_pkg::*;

`include "assert_macros.svh"

	logic        [31:0] seed_q;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	entry_t             q_wr_entry;
	entry_t             q_rd_entry;
	front_stat_t        front_stat;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_SEED) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_SEED) begin
			seed_q <= pwdata;
		end
	end

	mkh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.key_length  (key_length),
		.first_chunk (first_chunk),
		.last_chunk  (last_chunk),
		.q_push      (q_push),
		.q_full      (q_full),
		.q_entry     (q_wr_entry),
		.stat        (front_stat)
	);

	mkh_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (q_wr_entry),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_entry (q_rd_entry),
		.q_empty  (q_empty)
	);

	mkh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.q_empty    (q_empty),
		.q_entry    (q_rd_entry),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

	`ASSERT_IMPLY(a_push_not_full, q_push, !q_full, "queue pushed while full")
	`ASSERT_IMPLY(a_pop_not_empty, q_pop, !q_empty, "queue popped while empty")
	`ASSERT_IMPLY(a_full_has_s2, full, front_stat.valid_s2 && q_full, "front stalled without cause")
	`ASSERT_NEXT(a_stall_holds_s2, full, front_stat.valid_s2, "stalled chunk dropped from front")

endmodule

[dv/murmur2_key_hash_unit_tb.sv]
`timescale 1ns / 1ps
module murmur2_key_hash_unit_tb;
	import mkh_pkg::*;

	typedef struct {
		logic [31:0] data;
		logic [2:0]  count;
		logic [30:0] klen;
		logic        first;
		logic        last;
	} chunk_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = ADDR_SEED;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	logic [31:0]         data_word = '0;
	logic [2:0]          byte_count = '0;
	logic [30:0]         key_length = '0;
	logic                first_chunk = 1'b0;
	logic                last_chunk = 1'b0;
	logic                empty;
	logic                pop = 1'b0;
	logic [31:0]         hash_value;

	chunk_t              chunk_q[$];
	logic [31:0]         hash_q[$];
	logic [31:0]         seed_shadow = SEED_RESET;
	logic [31:0]         run_hash = '0;
	logic [31:0]         next_hash;
	logic [31:0]         want_hash;
	logic                req_taken = 1'b0;
	bit                  idle_on = 1'b1;
	int unsigned         gap_left = 0;
	int unsigned         stall_left = 0;
	int unsigned         errors = 0;
	int unsigned         chunks_taken = 0;
	int unsigned         keys_checked = 0;
	int unsigned         seeds_tried = 0;

	murmur2_key_hash_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.key_length  (key_length),
		.first_chunk (first_chunk),
		.last_chunk  (last_chunk),
		.empty       (empty),
		.pop         (pop),
		.hash_value  (hash_value)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] mix_chunk(logic [31:0] h, logic [31:0] w);
		logic [31:0] k;
		k = w * MIX_MUL;
		k ^= k >> MIX_SHIFT;
		k = k * MIX_MUL;
		return (h * MIX_MUL) ^ k;
	endfunction

	function automatic logic [31:0] fold_tail(logic [31:0] h, logic [31:0] w, logic [2:0] n);
		logic [31:0] mask;
		case (n)
			3'd0: return h;
			3'd1: mask = 32'h0000_00ff;
			3'd2: mask = 32'h0000_ffff;
			default: mask = 32'h00ff_ffff;
		endcase
		h ^= w & mask;
		return h * MIX_MUL;
	endfunction

	function automatic logic [31:0] final_mix(logic [31:0] h);
		h ^= h >> FIN_SHIFT_A;
		h = h * MIX_MUL;
		h ^= h >> FIN_SHIFT_B;
		return h;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < 40)
			$display("[%0t] mismatch on %s: got %08h, expected %08h", $time, what, got, want);
		errors++;
	endtask

	task automatic queue_chunk(logic [31:0] data, logic [2:0] count, logic [30:0] klen,
			logic first, logic last);
		chunk_t c;
		c.data = data;
		c.count = count;
		c.klen = klen;
		c.first = first;
		c.last = last;
		chunk_q.push_back(c);
	endtask

	// well-formed key: full chunks, then a tail or a last full chunk or an empty closer
	task automatic queue_key(int unsigned nbytes, logic [30:0] klen, bit pad_empty,
			bit junk_counts);
		int unsigned left;
		logic        first;
		logic [2:0]  cnt;
		left = nbytes;
		first = 1'b1;
		if (nbytes == 0) begin
			queue_chunk($urandom, 3'd0, klen, 1'b1, 1'b1);
			return;
		end
		while (left > 0) begin
			if (left > 4 || (left == 4 && pad_empty)) begin
				cnt = junk_counts ? 3'($urandom_range(0, 7)) : 3'd4;
				queue_chunk($urandom, cnt, first ? klen : 31'($urandom), first, 1'b0);
				left -= 4;
			end else begin
				queue_chunk($urandom, 3'(left), first ? klen : 31'($urandom), first, 1'b1);
				left = 0;
			end
			first = 1'b0;
		end
		if (pad_empty && nbytes % 4 == 0)
			queue_chunk($urandom, 3'd0, 31'($urandom), 1'b0, 1'b1);
	endtask

	task automatic queue_random_request();
		int unsigned r;
		int unsigned nbytes;
		int unsigned n;
		r = $urandom_range(0, 99);
		nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 16);
		if (r < 70) begin
			queue_key(nbytes, 31'(nbytes), nbytes % 4 == 0 && $urandom_range(0, 5) == 0,
				$urandom_range(0, 4) == 0);
		end else if (r < 80) begin
			// length field disagrees with the delivered bytes
			queue_key(nbytes, 31'($urandom), $urandom_range(0, 5) == 0, 1'b0);
		end else if (r < 90) begin
			// continuation with no first chunk
			n = $urandom_range(0, 3);
			repeat (n)
				queue_chunk($urandom, 3'($urandom_range(0, 7)), 31'($urandom), 1'b0, 1'b0);
			queue_chunk($urandom, 3'($urandom_range(0, 7)), 31'($urandom), 1'b0, 1'b1);
		end else begin
			queue_chunk($urandom, 3'($urandom_range(0, 7)), 31'($urandom),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic set_seed(logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_SEED;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		seed_shadow = value;
		seeds_tried++;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== value)
			report_mismatch("seed readback", prdata, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// queue drained, nothing outstanding, then room for chunks still in the pipeline
	task automatic wait_drained();
		@(negedge clk);
		while (chunk_q.size() != 0 || push || hash_q.size() != 0)
			@(negedge clk);
		repeat (30)
			@(negedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!push || req_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				push <= 1'b0;
			end else if (chunk_q.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
				gap_left <= $urandom_range(0, 5);
				push <= 1'b0;
			end else if (chunk_q.size() != 0) begin
				data_word <= chunk_q[0].data;
				byte_count <= chunk_q[0].count;
				key_length <= chunk_q[0].klen;
				first_chunk <= chunk_q[0].first;
				last_chunk <= chunk_q[0].last;
				void'(chunk_q.pop_front());
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 5);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// monitor: predict on accepted requests, check on accepted results
	always @(posedge clk) begin
		req_taken <= arst_n && push && !full;
		if (arst_n && push && !full) begin
			chunks_taken++;
			next_hash = first_chunk ? (seed_shadow ^ {1'b0, key_length}) : run_hash;
			if (last_chunk && byte_count < 3'd4)
				next_hash = fold_tail(next_hash, data_word, byte_count);
			else
				next_hash = mix_chunk(next_hash, data_word);
			run_hash = next_hash;
			if (last_chunk)
				hash_q.push_back(final_mix(next_hash));
		end
		if (arst_n && pop && !empty) begin
			if (hash_q.size() == 0) begin
				report_mismatch("unexpected result", hash_value, 32'h0);
			end else begin
				want_hash = hash_q.pop_front();
				keys_checked++;
				if (hash_value !== want_hash)
					report_mismatch("hash_value", hash_value, want_hash);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [31:0] seeds[5];
		int unsigned target;
		seeds[0] = 32'h0;
		seeds[1] = 32'hffff_ffff;
		seeds[2] = $urandom;
		seeds[3] = $urandom;
		seeds[4] = $urandom;

		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pass on the reset seed
		queue_chunk(32'h1234_5678, 3'd4, 31'd0, 1'b0, 1'b1);
		queue_chunk(32'hdead_beef, 3'd0, 31'd0, 1'b1, 1'b1);
		queue_chunk(32'hffff_ffff, 3'd1, 31'd1, 1'b1, 1'b1);
		queue_chunk(32'hffff_ffff, 3'd2, 31'd2, 1'b1, 1'b1);
		queue_chunk(32'hffff_ffff, 3'd3, 31'd3, 1'b1, 1'b1);
		queue_chunk(32'h0000_0000, 3'd4, 31'd4, 1'b1, 1'b1);
		queue_chunk(32'ha5a5_5a5a, 3'd4, 31'd4, 1'b1, 1'b0);
		queue_chunk(32'hffff_ffff, 3'd0, 31'd0, 1'b0, 1'b1);
		queue_chunk(32'hffff_ffff, 3'd4, 31'd8, 1'b1, 1'b0);
		queue_chunk(32'hffff_ffff, 3'd4, 31'd0, 1'b0, 1'b1);
		queue_chunk(32'h0403_0201, 3'd4, 31'd7, 1'b1, 1'b0);
		queue_chunk(32'hff07_0605, 3'd3, 31'd0, 1'b0, 1'b1);
		queue_chunk(32'h0000_00ff, 3'd1, 31'h7fff_ffff, 1'b1, 1'b1);
		queue_chunk(32'h8000_0001, 3'd5, 31'd5, 1'b1, 1'b1);
		queue_chunk(32'h0f0f_f0f0, 3'd6, 31'd6, 1'b1, 1'b1);
		queue_chunk(32'hffff_ffff, 3'd7, 31'h7fff_ffff, 1'b1, 1'b1);
		queue_chunk(32'h1111_2222, 3'd0, 31'd11, 1'b1, 1'b0);
		queue_chunk(32'h3333_4444, 3'd2, 31'd0, 1'b0, 1'b0);
		queue_chunk(32'h5566_7788, 3'd3, 31'd0, 1'b0, 1'b1);
		queue_chunk(32'h99aa_bbcc, 3'd2, 31'd0, 1'b0, 1'b1);
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			idle_on = (p != 4);
			set_seed(seeds[p]);
			target = 246;
			while (chunk_q.size() < target)
				queue_random_request();
			wait_drained();
		end

		while (hash_q.size() != 0)
			report_mismatch("missing result", 32'h0, hash_q.pop_front());

		$display("checked %0d key hashes from %0d accepted chunks under %0d seed settings",
			keys_checked, chunks_taken, seeds_tried + 1);
		$display("mismatches: %0d", errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[murmur2_key_hash_unit.f]
+incdir+hdl
hdl/mkh_pkg.sv
hdl/mkh_front.sv
hdl/mkh_fifo.sv
hdl/mkh_back.sv
hdl/murmur2_key_hash_unit.sv
dv/murmur2_key_hash_unit_tb.sv
